/* design/vmf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmf_pkg
// Shared constants of the volume median filter.
// ----------------------------------------------------------------------------
package vmf_pkg;
    localparam int MAX_DIM    = 32;
    localparam int MAX_KERNEL = 5;
    localparam int VALUE_BITS = 16;

    // Input operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_SIZE_X = 2'd1;
    localparam logic [1:0] REG_SIZE_Y = 2'd2;
    localparam logic [1:0] REG_SIZE_Z = 2'd3;

    localparam logic [2:0] KERNEL_RESET = 3'd3;
    localparam logic [5:0] SIZE_RESET   = 6'd32;
endpackage
`default_nettype wire

/* design/volume_median_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// volume_median_filter
// 3D median filter over a voxel volume held in on-chip memory.
// ----------------------------------------------------------------------------
// A load transaction writes one voxel and answers zeros in the next cycle.
// A query walks the clipped window once to count it, then selects the
// element of rank count/2 by a radix search from the top bit: each of the
// VALUE_BITS passes re-reads the whole window through the single memory
// port, one voxel per cycle, and counts voxels below the trial value. Each
// of the VALUE_BITS + 1 scans reads one voxel at a time, waits for the
// last read data, sees the scan end and is closed in S_TAIL; after the
// last pass the result goes from S_DONE into an output register. One item
// is worked at a time, and the next item is taken only once that result is
// taken, at the earliest in the same cycle. The voxel memory has no reset;
// a voxel must be written before it is read.
// ----------------------------------------------------------------------------
module volume_median_filter #(
    parameter int MAX_DIM    = vmf_pkg::MAX_DIM,
    parameter int MAX_KERNEL = vmf_pkg::MAX_KERNEL,
    parameter int VALUE_BITS = vmf_pkg::VALUE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [5:0]            i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_op,
    input  wire logic [4:0]            i_pos_x,
    input  wire logic [4:0]            i_pos_y,
    input  wire logic [4:0]            i_pos_z,
    input  wire logic [15:0]           i_voxel_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [15:0]                o_median_value,
    output logic [6:0]                 o_window_count
);
    localparam int CB    = $clog2(MAX_DIM);
    localparam int AB    = 3 * CB;
    localparam int DEPTH = 1 << AB;
    localparam int HMAX  = MAX_KERNEL / 2;
    localparam int EB    = $clog2(MAX_DIM + 1);
    localparam int NB    = $clog2((2 * HMAX + 1) ** 3 + 1);
    localparam int BB    = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE, S_COUNT, S_PASS, S_TAIL, S_DONE
    } t_state;

    // Configuration registers.
    logic [2:0] r_kernel;
    logic [5:0] r_size_x, r_size_y, r_size_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= vmf_pkg::KERNEL_RESET;
            r_size_x <= vmf_pkg::SIZE_RESET;
            r_size_y <= vmf_pkg::SIZE_RESET;
            r_size_z <= vmf_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vmf_pkg::REG_KERNEL: r_kernel <= i_cfg_data[2:0];
                vmf_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                vmf_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                vmf_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped extent minus one, as a coordinate.
    function automatic logic [CB-1:0] last_of(input logic [5:0] s);
        logic [EB:0] e;
        begin
            e = (EB+1)'(s);
            if (s == 6'd0) e = (EB+1)'(1);
            else if (e > (EB+1)'(MAX_DIM)) e = (EB+1)'(MAX_DIM);
            last_of = CB'(e - (EB+1)'(1));
        end
    endfunction

    // Saturated half-width of the window.
    logic [2:0] w_half;
    always_comb begin
        w_half = r_kernel >> 1;
        if (w_half > 3'(HMAX)) w_half = 3'(HMAX);
    end

    // Window bounds of one axis.
    function automatic logic [2*CB-1:0] bnd(input logic [4:0] p, input logic [5:0] s,
                                            input logic [2:0] h);
        logic [CB-1:0] l, pc, lo, hi;
        logic [CB+3:0] sum;
        begin
            l  = last_of(s);
            pc = (CB'(p) > l || (5'(CB'(p)) != p)) ? l : CB'(p);
            lo = ((CB+3)'(pc) >= (CB+3)'(h)) ? CB'((CB+3)'(pc) - (CB+3)'(h)) : '0;
            sum = (CB+4)'(pc) + (CB+4)'(h);
            hi = (sum < (CB+4)'(l)) ? CB'(sum) : l;
            bnd = {hi, lo};
        end
    endfunction

    // Window scan state and radix search registers.
    t_state              r_state;
    logic [CB-1:0]       r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic [CB-1:0]       r_x, r_y, r_z;
    logic                r_scan_end;   // scan address walked past last voxel
    logic                r_rd_valid;   // memory read data valid this cycle
    logic                r_phase_count; // the scan under way is the counting scan
    logic [NB-1:0]       r_count, r_less, r_rank;
    logic [VALUE_BITS-1:0] r_prefix;
    logic [BB-1:0]       r_bit;
    logic [VALUE_BITS-1:0] r_rdata;
    logic                r_out_valid;
    logic [15:0]         r_out_median;
    logic [6:0]          r_out_count;

    // Voxel memory addressed by the concatenated coordinates, one port
    // written on load and read on scan.
    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [AB-1:0]         w_addr;
    logic                  w_wr, w_rd;

    assign w_wr = i_valid && o_ready && (i_op == vmf_pkg::OP_LOAD)
                  && (int'(i_pos_x) < MAX_DIM) && (int'(i_pos_y) < MAX_DIM)
                  && (int'(i_pos_z) < MAX_DIM);
    assign w_addr = w_wr ? {CB'(i_pos_z), CB'(i_pos_y), CB'(i_pos_x)}
                         : {r_z, r_y, r_x};
    assign w_rd = (r_state == S_COUNT || r_state == S_PASS) && !r_scan_end;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_addr] <= VALUE_BITS'(i_voxel_value);
        if (w_rd) r_rdata <= r_mem[w_addr];
    end

    assign o_ready        = (r_state == S_IDLE) && !(r_out_valid && !i_ready);
    assign o_valid        = r_out_valid;
    assign o_median_value = r_out_median;
    assign o_window_count = r_out_count;

    // A result enters the output register on a load or at the end of a query.
    logic w_out_load;
    assign w_out_load = (r_state == S_IDLE && i_valid && o_ready
                         && i_op == vmf_pkg::OP_LOAD)
                        || (r_state == S_DONE && (!r_out_valid || i_ready));

    // Trial value of the current pass: prefix with the current bit set.
    logic [VALUE_BITS-1:0] w_trial;
    assign w_trial = r_prefix | (VALUE_BITS'(1) << r_bit);

    logic [2*CB-1:0] w_bx, w_by, w_bz;
    assign w_bx = bnd(i_pos_x, r_size_x, w_half);
    assign w_by = bnd(i_pos_y, r_size_y, w_half);
    assign w_bz = bnd(i_pos_z, r_size_z, w_half);

    // Marks that the scan under way is the counting scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase_count <= 1'b0;
        else if (r_state == S_IDLE) r_phase_count <= 1'b1;
        else if (r_state == S_TAIL) r_phase_count <= 1'b0;
    end

    // Sequencer: counts the window, then one scan per value bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_scan_end  <= 1'b0;
        end else begin
            if (w_out_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            r_rd_valid <= w_rd;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        if (i_op == vmf_pkg::OP_LOAD) begin
                            r_out_median <= '0;
                            r_out_count  <= '0;
                        end else begin
                            {r_x1, r_x0} <= w_bx;
                            {r_y1, r_y0} <= w_by;
                            {r_z1, r_z0} <= w_bz;
                            r_x <= w_bx[CB-1:0];
                            r_y <= w_by[CB-1:0];
                            r_z <= w_bz[CB-1:0];
                            r_scan_end <= 1'b0;
                            r_count <= '0;
                            r_less  <= '0;
                            r_prefix <= '0;
                            r_bit   <= BB'(VALUE_BITS - 1);
                            r_state <= S_COUNT;
                        end
                    end
                end
                S_COUNT, S_PASS: begin
                    // Advance the scan address in x, then y, then z.
                    if (!r_scan_end) begin
                        if (r_x != r_x1) r_x <= r_x + CB'(1);
                        else begin
                            r_x <= r_x0;
                            if (r_y != r_y1) r_y <= r_y + CB'(1);
                            else begin
                                r_y <= r_y0;
                                if (r_z != r_z1) r_z <= r_z + CB'(1);
                                else begin
                                    r_z <= r_z0;
                                    r_scan_end <= 1'b1;
                                end
                            end
                        end
                    end
                    if (r_state == S_COUNT) begin
                        if (r_rd_valid) r_count <= r_count + NB'(1);
                    end else if (r_rd_valid && r_rdata < w_trial) begin
                        r_less <= r_less + NB'(1);
                    end
                    if (r_scan_end && !r_rd_valid) r_state <= S_TAIL;
                end
                S_TAIL: begin
                    // Close one scan: fix the rank, or decide one bit of the result.
                    r_scan_end <= 1'b0;
                    r_less     <= '0;
                    if (r_phase_count) begin
                        r_rank  <= r_count >> 1;
                        r_state <= S_PASS;
                    end else begin
                        if (r_less <= r_rank) r_prefix <= w_trial;
                        if (r_bit == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_bit   <= r_bit - BB'(1);
                            r_state <= S_PASS;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_median <= 16'(r_prefix);
                        r_out_count  <= 7'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_median_value))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_count != '0)
        else $error("empty window");
`endif
endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the volume median filter.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, value extremes, clamped query
// positions and a zero kernel. Random phases then reprogram the kernel and
// extents, also outside their nominal ranges, fill every voxel that the
// volume can read, and mix random loads with random queries. Each result
// is checked against a table entry or a local predictor of the window
// median; both item handshakes see random idle cycles but in no_idle phases.
// ----------------------------------------------------------------------------
module tb;
    localparam int  DEPTH       = vmf_pkg::MAX_DIM * vmf_pkg::MAX_DIM * vmf_pkg::MAX_DIM;
    localparam int  WIN_MAX     = 125;
    localparam int  CYCLE_LIMIT = 4000000;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        op;
        logic [4:0]  x, y, z;
        logic [15:0] value;
        logic [1:0]  index;
        logic [5:0]  data;
        bit          typed;
        logic [15:0] med;
        logic [6:0]  cnt;
    } t_stim_row;

    typedef struct {
        logic [15:0] med;
        logic [6:0]  cnt;
    } t_median_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [5:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = vmf_pkg::OP_LOAD;
    logic [4:0]  i_pos_x = '0;
    logic [4:0]  i_pos_y = '0;
    logic [4:0]  i_pos_z = '0;
    logic [15:0] i_voxel_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_median_value;
    logic [6:0]  o_window_count;

    volume_median_filter i_dut (.*);

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the block state.
    logic [15:0]    vox_mem [DEPTH];
    bit             vox_written [DEPTH];
    logic [2:0]     kernel_reg = vmf_pkg::KERNEL_RESET;
    logic [5:0]     size_reg [3] = '{vmf_pkg::SIZE_RESET, vmf_pkg::SIZE_RESET,
                                     vmf_pkg::SIZE_RESET};
    t_median_result median_q [$];
    int             errors = 0;
    int             cycles = 0;
    bit             no_idle = 1'b0;
    bit             row_typed = 1'b0;
    t_median_result row_result;
    t_stim_row      dir_rows [$];

    function automatic int eff_extent(logic [5:0] s);
        if (s == 0) return 1;
        if (s > vmf_pkg::MAX_DIM) return vmf_pkg::MAX_DIM;
        return int'(s);
    endfunction

    // Median of the clipped window around a query position.
    function automatic t_median_result window_median(logic [4:0] px, logic [4:0] py,
                                                     logic [4:0] pz);
        int             lo [3], hi [3], p [3];
        int             h, last, n, j;
        logic [15:0]    win [WIN_MAX];
        logic [15:0]    v;
        t_median_result r;
        h = int'(kernel_reg) / 2;
        if (h > vmf_pkg::MAX_KERNEL / 2) h = vmf_pkg::MAX_KERNEL / 2;
        p[0] = px; p[1] = py; p[2] = pz;
        for (int a = 0; a < 3; a++) begin
            last = eff_extent(size_reg[a]) - 1;
            if (p[a] > last) p[a] = last;
            lo[a] = (p[a] >= h) ? p[a] - h : 0;
            hi[a] = (p[a] + h < last) ? p[a] + h : last;
        end
        n = 0;
        for (int z = lo[2]; z <= hi[2]; z++)
            for (int y = lo[1]; y <= hi[1]; y++)
                for (int x = lo[0]; x <= hi[0]; x++) begin
                    v = vox_mem[(z * vmf_pkg::MAX_DIM + y) * vmf_pkg::MAX_DIM + x];
                    // Insertion into the ascending window.
                    j = n;
                    while (j > 0 && win[j - 1] > v) begin
                        win[j] = win[j - 1];
                        j--;
                    end
                    win[j] = v;
                    n++;
                end
        r.med = win[n / 2];
        r.cnt = 7'(n);
        return r;
    endfunction

    // Accepted input transaction: update the mirror and queue the expectation.
    always @(posedge i_clk) begin
        t_median_result r;
        int             addr;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && o_ready) begin
            r = '{16'd0, 7'd0};
            if (i_op == vmf_pkg::OP_LOAD) begin
                addr = (int'(i_pos_z) * vmf_pkg::MAX_DIM + int'(i_pos_y))
                       * vmf_pkg::MAX_DIM + int'(i_pos_x);
                vox_mem[addr] = i_voxel_value;
                vox_written[addr] = 1'b1;
            end else begin
                r = window_median(i_pos_x, i_pos_y, i_pos_z);
            end
            median_q.insert(median_q.size(), row_typed ? row_result : r);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                vmf_pkg::REG_KERNEL: kernel_reg = i_cfg_data[2:0];
                vmf_pkg::REG_SIZE_X: size_reg[0] = i_cfg_data;
                vmf_pkg::REG_SIZE_Y: size_reg[1] = i_cfg_data;
                vmf_pkg::REG_SIZE_Z: size_reg[2] = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result transaction check.
    always @(posedge i_clk) begin
        t_median_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (median_q.size() == 0) begin
                $display("%0t: expected no result, actual median=%h count=%0d", $time,
                         o_median_value, o_window_count);
                errors++;
            end else begin
                e = median_q.pop_front();
                if (o_median_value !== e.med) begin
                    $display("%0t: median_value expected %h actual %h", $time,
                             e.med, o_median_value);
                    errors++;
                end
                if (o_window_count !== e.cnt) begin
                    $display("%0t: window_count expected %0d actual %0d", $time,
                             e.cnt, o_window_count);
                    errors++;
                end
            end
        end
    end

    // Receiver with random stalls.
    initial begin
        int k;
        @(posedge i_clk iff i_rst_n);
        forever begin
            k = no_idle ? 0 : $urandom_range(0, 4);
            if (k > 0) begin
                i_ready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Timeout.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("volume_median_filter regression: fail");
            $finish;
        end
    end

    task automatic put_voxel_op(logic op, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                                logic [15:0] value, bit typed, t_median_result r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_typed <= typed;
        row_result <= r;
        i_valid <= 1'b1;
        i_op <= op;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_voxel_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Let the block drain before a register write.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [5:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void add_row(t_stim_row s);
        dir_rows.insert(dir_rows.size(), s);
    endfunction

    function automatic t_stim_row voxel_row(logic op, int x, int y, int z, int value,
                                            bit typed = 0, int med = 0, int cnt = 0);
        t_stim_row s;
        s = '{ROW_ITEM, op, 5'(x), 5'(y), 5'(z), 16'(value), 2'd0, 6'd0,
              typed, 16'(med), 7'(cnt)};
        return s;
    endfunction

    function automatic t_stim_row reg_row(logic [1:0] index, int data);
        t_stim_row s;
        s = '{ROW_CFG, vmf_pkg::OP_LOAD, 5'd0, 5'd0, 5'd0, 16'd0, index, 6'(data),
              1'b0, 16'd0, 7'd0};
        return s;
    endfunction

    // Random value, often from a small set so that the window holds ties.
    function automatic logic [15:0] draw_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3)) * 16'h5555;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int             ext [3];
        logic [5:0]     sizes [3];
        logic [2:0]     kernels [8] = '{3'd0, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6, 3'd4, 3'd3};
        t_stim_row      row;
        t_median_result r;

        // Directed table: corner voxels around the origin, then clamped queries.
        add_row(voxel_row(vmf_pkg::OP_LOAD, 31, 31, 31, 16'hFFFF, 1, 0, 0));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 0, 0, 0, 16'h0000, 1, 0, 0));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 1, 0, 0, 16'h1234));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 0, 1, 0, 16'hFFFF));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 1, 1, 0, 16'h0001));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 0, 0, 1, 16'h8000));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 1, 0, 1, 16'h7FFF));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 0, 1, 1, 16'h0001));
        add_row(voxel_row(vmf_pkg::OP_LOAD, 1, 1, 1, 16'hAAAA));
        add_row(voxel_row(vmf_pkg::OP_QUERY, 0, 0, 0, 16'hFFFF));
        add_row(reg_row(vmf_pkg::REG_KERNEL, 5));
        add_row(reg_row(vmf_pkg::REG_SIZE_X, 1));
        add_row(reg_row(vmf_pkg::REG_SIZE_Y, 1));
        add_row(reg_row(vmf_pkg::REG_SIZE_Z, 1));
        // Position far outside a one-voxel volume clamps to the origin.
        add_row(voxel_row(vmf_pkg::OP_QUERY, 31, 31, 31, 0, 1, 16'h0000, 1));
        add_row(reg_row(vmf_pkg::REG_KERNEL, 0));
        add_row(reg_row(vmf_pkg::REG_SIZE_X, 2));
        // Zero kernel reads the single clamped voxel.
        add_row(voxel_row(vmf_pkg::OP_QUERY, 31, 0, 0, 0, 1, 16'h1234, 1));
        add_row(reg_row(vmf_pkg::REG_KERNEL, 3));
        add_row(reg_row(vmf_pkg::REG_SIZE_Y, 2));
        add_row(reg_row(vmf_pkg::REG_SIZE_Z, 2));
        add_row(voxel_row(vmf_pkg::OP_QUERY, 1, 1, 1, 0));
        add_row(voxel_row(vmf_pkg::OP_QUERY, 0, 1, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.index, row.data);
            end else begin
                r = '{row.med, row.cnt};
                put_voxel_op(row.op, row.x, row.y, row.z, row.value, row.typed, r);
            end
        end

        // Random phases, each with its own kernel and extents.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: sizes = '{6'd63, 6'd0, 6'd1};
                1: sizes = '{6'd1, 6'd32, 6'd2};
                2: sizes = '{6'd2, 6'd1, 6'd33};
                3: sizes = '{6'd4, 6'd4, 6'd4};
                default: begin
                    foreach (sizes[a]) sizes[a] = 6'($urandom_range(0, 5));
                end
            endcase
            no_idle = (ph % 3 == 2);
            write_reg(vmf_pkg::REG_KERNEL, 6'(kernels[ph]));
            write_reg(vmf_pkg::REG_SIZE_X, sizes[0]);
            write_reg(vmf_pkg::REG_SIZE_Y, sizes[1]);
            write_reg(vmf_pkg::REG_SIZE_Z, sizes[2]);
            foreach (ext[a]) ext[a] = eff_extent(sizes[a]);

            // Fill every voxel of the volume that has not been written yet.
            for (int z = 0; z < ext[2]; z++)
                for (int y = 0; y < ext[1]; y++)
                    for (int x = 0; x < ext[0]; x++)
                        if (!vox_written[(z * vmf_pkg::MAX_DIM + y) * vmf_pkg::MAX_DIM + x])
                            put_voxel_op(vmf_pkg::OP_LOAD, 5'(x), 5'(y), 5'(z),
                                         draw_value(), 0, r);

            // Mixed loads and queries over the whole coordinate range.
            for (int n = 0; n < 6; n++) begin
                put_voxel_op($urandom_range(0, 1) ? vmf_pkg::OP_QUERY : vmf_pkg::OP_LOAD,
                             5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                             5'($urandom_range(0, 31)), draw_value(), 0, r);
            end
        end

        no_idle = 1'b0;
        wait_drained();
        if (errors == 0) begin
            $display("volume_median_filter regression: pass");
        end else begin
            $display("volume_median_filter regression: fail");
        end
        $finish;
    end
endmodule

/* volume_median_filter.f */
design/vmf_pkg.sv
design/volume_median_filter.sv
test/tb.sv
